/* design/drive_distance_pid_with_heading_hold_top_macros.svh */
// Assertion helpers for the drive distance controller.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef DRIVE_DISTANCE_PID_WITH_HEADING_HOLD_TOP_MACROS_SVH
`define DRIVE_DISTANCE_PID_WITH_HEADING_HOLD_TOP_MACROS_SVH

// same-cycle implication
`define DDPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ddph_pkg.sv */
package ddph_pkg;

  localparam int ErrW   = 25;
  localparam int DerW   = 26;
  localparam int SumW   = 40;
  localparam int SumLoW = 20;
  localparam int MulAW  = 17;
  localparam int MulBW  = 26;
  localparam int ProdW  = MulAW + MulBW;
  localparam int AccW   = 64;
  localparam int PidW   = 8;
  localparam int PosW   = 24;
  localparam int HeadW  = 9;
  localparam int HdW    = 11;
  localparam int DriveW = 18;
  localparam int CalcW  = 21;
  localparam int GainW  = 16;
  localparam int SpeedW = 7;

  localparam int DistScale   = 68;
  localparam int SettleBand  = 100;
  localparam int SettleLimit = 10;
  localparam int StallBand   = 5;
  localparam int StallLimit  = 500;
  localparam int WarmupTicks = 2;
  localparam int HeadGain    = 500;
  localparam int HalfTurn    = 180;
  localparam int FullTurn    = 360;
  // 12000 = 127*94 + 62
  localparam int MvDen       = 127;
  localparam int MvQuot      = 94;
  localparam int MvRem       = 62;
  // floor(2^20 / 127): quotient estimate is exact or one short
  localparam int RecipShift  = 20;
  localparam int RecipM      = 8256;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_TARGET     = 3'd3,
    REG_MAX_SPEED  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CAUSE_RUN     = 2'd0,
    CAUSE_SETTLED = 2'd1,
    CAUSE_STALLED = 2'd2
  } cause_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_ACC,
    ST_SCALE,
    ST_RECIP,
    ST_MUL_Q,
    ST_FIX,
    ST_FINAL
  } st_e;

  typedef struct packed {
    logic        [GainW-1:0]  prop_gain;
    logic        [GainW-1:0]  integ_gain;
    logic        [GainW-1:0]  deriv_gain;
    logic signed [GainW-1:0]  target_distance;
    logic        [SpeedW-1:0] max_speed;
  } cfg_t;

endpackage

/* design/ddph_mul.sv */
module ddph_mul (
  input  logic                                clk_i,
  input  logic signed [ddph_pkg::MulAW-1:0]   a_i,
  input  logic signed [ddph_pkg::MulBW-1:0]   b_i,
  output logic signed [ddph_pkg::ProdW-1:0]   prod_o
);
  import ddph_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  // registered product, one per cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

/* design/ddph_cfg.sv */
module ddph_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output ddph_pkg::cfg_t        cfg_o
);
  import ddph_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:  cfg_d.prop_gain       = pwdata[GainW-1:0];
        REG_INTEG_GAIN: cfg_d.integ_gain      = pwdata[GainW-1:0];
        REG_DERIV_GAIN: cfg_d.deriv_gain      = pwdata[GainW-1:0];
        REG_TARGET:     cfg_d.target_distance = $signed(pwdata[GainW-1:0]);
        REG_MAX_SPEED:  cfg_d.max_speed       = pwdata[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:  prdata = 32'(cfg_q.prop_gain);
      REG_INTEG_GAIN: prdata = 32'(cfg_q.integ_gain);
      REG_DERIV_GAIN: prdata = 32'(cfg_q.deriv_gain);
      REG_TARGET:     prdata = 32'($unsigned(cfg_q.target_distance));
      REG_MAX_SPEED:  prdata = 32'(cfg_q.max_speed);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= 16'd1280;
      cfg_q.integ_gain      <= 16'd0;
      cfg_q.deriv_gain      <= 16'd8960;
      cfg_q.target_distance <= 16'sd0;
      cfg_q.max_speed       <= 7'd127;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/ddph_core.sv */
module ddph_core #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ddph_pkg::cfg_t                    cfg_i,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic                              s_cmd_i,
  input  logic signed [ddph_pkg::PosW-1:0]  s_pos_i,
  input  logic        [ddph_pkg::HeadW-1:0] s_head_i,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [ddph_pkg::DriveW-1:0]       m_left_o,
  output logic [ddph_pkg::DriveW-1:0]       m_right_o,
  output logic                              m_done_o,
  output logic [1:0]                        m_cause_o
);
  import ddph_pkg::*;

  localparam logic signed [AccW-1:0] RoundBias = (AccW'(1) <<< GAIN_FRAC_BITS) - AccW'(1);
  localparam logic signed [SumW-1:0] SumMax    = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin    = {1'b1, {(SumW-1){1'b0}}};

  // control and move state
  st_e                     st_q, st_d;
  logic                    m_valid_q, m_valid_d;
  logic signed [ErrW-1:0]  last_q, last_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [3:0]              settle_q, settle_d;
  logic [9:0]              stall_q, stall_d;
  logic [1:0]              warm_q, warm_d;
  logic [HeadW-1:0]        hold_q, hold_d;
  logic                    fin_q, fin_d;
  cause_e                  cause_q, cause_d;

  // datapath
  logic signed [PosW-1:0]  pos_q, pos_d;
  logic [HeadW-1:0]        head_q, head_d;
  logic                    zero_q, zero_d;
  logic signed [ErrW-1:0]  err_q, err_d;
  logic signed [DerW-1:0]  der_q, der_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [PidW-1:0]  pid_q, pid_d;
  logic                    tneg_q, tneg_d;
  logic [12:0]             tmag_q, tmag_d;
  logic signed [14:0]      pid94_q, pid94_d;
  logic signed [19:0]      h500_q, h500_d;
  logic [6:0]              qm_q, qm_d;
  logic [6:0]              rm_q, rm_d;
  logic [DriveW-1:0]       left_q, left_d, right_q, right_d;
  logic                    done_q, done_d;
  cause_e                  ocause_q, ocause_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;

  // working signals
  logic                    s_acc, out_ld;
  logic signed [SumW:0]    sum_wide;
  logic signed [SumW-1:0]  sum_sat, sum_new;
  logic signed [AccW-1:0]  biased, shifted;
  logic signed [PidW-1:0]  lim, nlim;
  logic [4:0]              settle_n;
  logic [10:0]             stall_n;
  logic signed [13:0]      t62;
  logic signed [HdW-1:0]   hd, hw;
  logic [6:0]              q0;
  logic [13:0]             rem;
  logic signed [PidW-1:0]  qf;
  logic [6:0]              rf;
  logic signed [CalcW-1:0] sl, sr, dl, dr;

  ddph_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign s_ready_o = (st_q == ST_IDLE);
  assign s_acc     = s_valid_i & s_ready_o;
  assign out_ld    = (st_q == ST_FINAL) & (~m_valid_q | m_ready_i);

  // operand select for the shared multiplier
  always_comb begin
    case (st_q)
      ST_MUL_P: begin
        mul_a = $signed({1'b0, cfg_i.prop_gain});
        mul_b = MulBW'(err_q);
      end
      ST_MUL_D: begin
        mul_a = $signed({1'b0, cfg_i.deriv_gain});
        mul_b = der_q;
      end
      ST_MUL_IL: begin
        mul_a = $signed({1'b0, cfg_i.integ_gain});
        mul_b = $signed({{(MulBW-SumLoW){1'b0}}, sum_q[SumLoW-1:0]});
      end
      ST_MUL_IH: begin
        mul_a = $signed({1'b0, cfg_i.integ_gain});
        mul_b = MulBW'($signed(sum_q[SumW-1:SumLoW]));
      end
      ST_MUL_Q: begin
        mul_a = MulAW'(RecipM);
        mul_b = $signed({{(MulBW-13){1'b0}}, tmag_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // arithmetic pieces, each used in one state
  always_comb begin
    // saturating integral, cleared on an error signum change
    sum_wide = (SumW+1)'(sum_q) + (SumW+1)'(err_q);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
    sum_new = (cfg_i.integ_gain != '0) ? sum_sat : sum_q;
    if ((err_q[ErrW-1] != last_q[ErrW-1]) || ((err_q == '0) != (last_q == '0))) begin
      sum_new = '0;
    end

    // Q-format scale, truncating toward zero, then clamp
    biased  = acc_q + (acc_q[AccW-1] ? RoundBias : AccW'(0));
    shifted = biased >>> GAIN_FRAC_BITS;
    lim     = $signed({1'b0, cfg_i.max_speed});
    nlim    = -lim;

    settle_n = ((err_q < ErrW'(SettleBand)) && (err_q > ErrW'(-SettleBand))) ?
               5'({1'b0, settle_q} + 5'd1) : 5'd0;
    stall_n  = ((der_q < DerW'(StallBand)) && (der_q > DerW'(-StallBand))) ?
               11'({1'b0, stall_q} + 11'd1) : {1'b0, stall_q};

    // heading error with wrap
    t62 = 14'(pid_q) * 14'(MvRem);
    hd  = $signed({2'b0, hold_q}) - $signed({2'b0, head_q});
    if (hd > HdW'(HalfTurn)) begin
      hw = hd - HdW'(FullTurn);
    end else if (hd < HdW'(-HalfTurn)) begin
      hw = hd + HdW'(FullTurn);
    end else begin
      hw = hd;
    end

    // reciprocal quotient and one correction step
    q0  = prod[RecipShift+6:RecipShift];
    rem = 14'(tmag_q) - 14'(q0) * 14'(MvDen);

    // floor quotient and remainder of the signed fraction term
    if (!tneg_q) begin
      qf = $signed({1'b0, qm_q});
      rf = rm_q;
    end else if (rm_q == '0) begin
      qf = -$signed({1'b0, qm_q});
      rf = '0;
    end else begin
      qf = -$signed({1'b0, qm_q}) - PidW'(1);
      rf = 7'(7'(MvDen) - rm_q);
    end
    sl = CalcW'(pid94_q) + CalcW'(h500_q) + CalcW'(qf);
    sr = CalcW'(pid94_q) - CalcW'(h500_q) + CalcW'(qf);
    dl = sl + CalcW'((sl < 0) && (rf != '0));
    dr = sr + CalcW'((sr < 0) && (rf != '0));
  end

  // sequencer
  always_comb begin
    st_d      = st_q;
    m_valid_d = m_valid_q;
    last_d    = last_q;
    sum_d     = sum_q;
    settle_d  = settle_q;
    stall_d   = stall_q;
    warm_d    = warm_q;
    hold_d    = hold_q;
    fin_d     = fin_q;
    cause_d   = cause_q;
    pos_d     = pos_q;
    head_d    = head_q;
    zero_d    = zero_q;
    err_d     = err_q;
    der_d     = der_q;
    acc_d     = acc_q;
    pid_d     = pid_q;
    tneg_d    = tneg_q;
    tmag_d    = tmag_q;
    pid94_d   = pid94_q;
    h500_d    = h500_q;
    qm_d      = qm_q;
    rm_d      = rm_q;
    left_d    = left_q;
    right_d   = right_q;
    done_d    = done_q;
    ocause_d  = ocause_q;

    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          pos_d  = s_pos_i;
          head_d = s_head_i;
          if (cmd_e'(s_cmd_i) == CMD_START) begin
            last_d   = '0;
            sum_d    = '0;
            settle_d = '0;
            stall_d  = '0;
            warm_d   = '0;
            fin_d    = 1'b0;
            cause_d  = CAUSE_RUN;
            hold_d   = s_head_i;
            zero_d   = 1'b1;
            st_d     = ST_FINAL;
          end else if (fin_q) begin
            zero_d = 1'b1;
            st_d   = ST_FINAL;
          end else begin
            zero_d = 1'b0;
            st_d   = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        err_d = ErrW'(cfg_i.target_distance) * ErrW'(DistScale) - ErrW'(pos_q);
        st_d  = ST_MUL_P;
      end
      ST_MUL_P: begin
        der_d  = DerW'(err_q) - DerW'(last_q);
        last_d = err_q;
        sum_d  = sum_new;
        acc_d  = '0;
        st_d   = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_d = acc_q + AccW'(prod);
        st_d  = ST_MUL_IL;
      end
      ST_MUL_IL: begin
        acc_d = acc_q + AccW'(prod);
        st_d  = ST_MUL_IH;
      end
      ST_MUL_IH: begin
        acc_d = acc_q + AccW'(prod);
        st_d  = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + (AccW'(prod) <<< SumLoW);
        st_d  = ST_SCALE;
      end
      ST_SCALE: begin
        if (shifted > AccW'(lim)) begin
          pid_d = lim;
        end else if (shifted < AccW'(nlim)) begin
          pid_d = nlim;
        end else begin
          pid_d = shifted[PidW-1:0];
        end
        if (warm_q < 2'(WarmupTicks)) begin
          warm_d = warm_q + 2'd1;
          zero_d = 1'b1;
        end else begin
          settle_d = settle_n[3:0];
          stall_d  = stall_n[9:0];
          if (settle_n > 5'(SettleLimit)) begin
            fin_d   = 1'b1;
            cause_d = CAUSE_SETTLED;
          end else if (stall_n > 11'(StallLimit)) begin
            fin_d   = 1'b1;
            cause_d = CAUSE_STALLED;
          end
        end
        st_d = ST_RECIP;
      end
      ST_RECIP: begin
        tneg_d  = t62[13];
        tmag_d  = t62[13] ? 13'(-t62) : t62[12:0];
        pid94_d = 15'(pid_q) * 15'(MvQuot);
        h500_d  = 20'(hw) * 20'(HeadGain);
        st_d    = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        // reciprocal product of the registered magnitude
        st_d = ST_FIX;
      end
      ST_FIX: begin
        if (rem >= 14'(MvDen)) begin
          qm_d = q0 + 7'd1;
          rm_d = 7'(rem - 14'(MvDen));
        end else begin
          qm_d = q0;
          rm_d = rem[6:0];
        end
        st_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (out_ld) begin
          m_valid_d = 1'b1;
          done_d    = fin_q;
          ocause_d  = fin_q ? cause_q : CAUSE_RUN;
          if (zero_q || fin_q) begin
            left_d  = '0;
            right_d = '0;
          end else begin
            left_d  = dl[DriveW-1:0];
            right_d = dr[DriveW-1:0];
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      m_valid_q <= 1'b0;
      last_q    <= '0;
      sum_q     <= '0;
      settle_q  <= '0;
      stall_q   <= '0;
      warm_q    <= '0;
      hold_q    <= '0;
      fin_q     <= 1'b0;
      cause_q   <= CAUSE_RUN;
    end else begin
      st_q      <= st_d;
      m_valid_q <= m_valid_d;
      last_q    <= last_d;
      sum_q     <= sum_d;
      settle_q  <= settle_d;
      stall_q   <= stall_d;
      warm_q    <= warm_d;
      hold_q    <= hold_d;
      fin_q     <= fin_d;
      cause_q   <= cause_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    head_q   <= head_d;
    zero_q   <= zero_d;
    err_q    <= err_d;
    der_q    <= der_d;
    acc_q    <= acc_d;
    pid_q    <= pid_d;
    tneg_q   <= tneg_d;
    tmag_q   <= tmag_d;
    pid94_q  <= pid94_d;
    h500_q   <= h500_d;
    qm_q     <= qm_d;
    rm_q     <= rm_d;
    left_q   <= left_d;
    right_q  <= right_d;
    done_q   <= done_d;
    ocause_q <= ocause_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_left_o  = left_q;
  assign m_right_o = right_q;
  assign m_done_o  = done_q;
  assign m_cause_o = ocause_q;

endmodule

/* design/drive_distance_pid_with_heading_hold_top.sv */
// Channel   Dir  Handshake              Payload
// config    in   psel/penable/pwrite    5 registers at byte address 4*index, 32-bit data
// s_axis    in   tvalid/tready          tuser: cmd; tdata: position, heading
// m_axis    out  tvalid/tready          tuser: done_res, stop_cause; tdata: left, right
//
// Control tick: steps prep, P, D, two integral multiplies, accumulate, scale, reciprocal,
// quotient multiply, fix, final; no new item until the result is loaded. The four PID products
// (P, D, two integral halves) and the divide-by-127 reciprocal share one 17x26 multiplier,
// one registered product per cycle. Start item or tick after the move ended: straight to final.
// Reset restores the default gains and clears all move state.
// Input is taken only while idle; a stalled result holds the sequencer in its last step.
`include "drive_distance_pid_with_heading_hold_top_macros.svh"

module drive_distance_pid_with_heading_hold_top #(
  parameter int GAIN_FRAC_BITS = 8   // fraction bits of the gain registers
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [23:0] position, [32:24] heading, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [17:0] left_drive, [35:18] right_drive, rest zero
  output logic [2:0]  m_axis_tuser    // [0] done_res, [2:1] stop_cause
);
  import ddph_pkg::*;

  cfg_t              cfg;
  logic [DriveW-1:0] left_drive, right_drive;
  logic              done_res;
  logic [1:0]        stop_cause;

  // register file, read live by the core on every tick
  ddph_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer, shared multiplier and output register
  ddph_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_cmd_i   (s_axis_tuser[0]),
    .s_pos_i   ($signed(s_axis_tdata[PosW-1:0])),
    .s_head_i  (s_axis_tdata[PosW+HeadW-1:PosW]),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_left_o  (left_drive),
    .m_right_o (right_drive),
    .m_done_o  (done_res),
    .m_cause_o (stop_cause)
  );

  assign m_axis_tdata = {4'b0, right_drive, left_drive};
  assign m_axis_tuser = {stop_cause, done_res};

  // one item at a time: the core leaves idle on every accept
  `DDPH_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy accept")

  // an ended move always reports zero drives
  `DDPH_ASSERT_IMP(a_done_zero, m_axis_tvalid && done_res, m_axis_tdata == '0, "drive after end")

  // a stop cause is given exactly when the move has ended
  `DDPH_ASSERT_IMP(a_cause_done, m_axis_tvalid, (stop_cause != 2'b00) == done_res, "cause vs done")

endmodule
